// File: src/i2a_pkg.sv
// Shared types, constants and helpers for the integer to ASCII digit converter.
package i2a_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] REQ_SDEC = 2'd0;
    localparam logic [1:0] REQ_UDEC = 2'd1;
    localparam logic [1:0] REQ_HEXL = 2'd2;
    localparam logic [1:0] REQ_HEXU = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_UP_A  = 7'h41;
    localparam logic [6:0] CH_LO_A  = 7'h61;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;
    localparam logic [3:0] DIG_TEN     = 4'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } t_res;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? CH_UP_A : CH_LO_A;
        if (d < DIG_TEN) begin
            return CH_ZERO + {3'b000, d};
        end
        return base + {3'b000, d - DIG_TEN};
    endfunction

endpackage

// File: src/i2a_dabble.sv
// One shift-and-add-3 step of the binary to BCD converter.
module i2a_dabble
    import i2a_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NDIG      = 10
) (
    input  logic [4*NDIG-1:0]    i_bcd,
    input  logic [WORD_BITS-1:0] i_bin,
    output logic [4*NDIG-1:0]    o_bcd,
    output logic [WORD_BITS-1:0] o_bin
);

    logic [4*NDIG-1:0] w_adj;

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (i_bcd[k*4 +: 4] >= BCD_ADJ_MIN) begin
                w_adj[k*4 +: 4] = i_bcd[k*4 +: 4] + BCD_ADJ_ADD;
            end else begin
                w_adj[k*4 +: 4] = i_bcd[k*4 +: 4];
            end
        end
    end

    assign o_bcd = {w_adj[4*NDIG-2:0], i_bin[WORD_BITS-1]};
    assign o_bin = {i_bin[WORD_BITS-2:0], 1'b0};

endmodule

// File: src/integer_to_ascii_digits.sv
// Top level: formats one word as ASCII sign and digits, one character per beat.
// Decimal first runs the shift-add-3 steps in ST_CONV, then ST_SKIP steps past leading zeros
// (the sign beat leaves as ST_SKIP ends) and ST_EMIT emits one beat per digit; hex skips the
// shift-add-3 steps. start is taken only while idle; busy drops as the last beat shows, and
// there is no receiver stall.
// Reset is synchronous and active low; it returns the sequencer to idle and drops o_valid.
module integer_to_ascii_digits
    import i2a_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    localparam int NDEC = (WORD_BITS * 1233) / 4096 + 1;
    localparam int NHEX = (WORD_BITS + 3) / 4;
    localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int BW   = 4 * NDIG;
    localparam int IW   = $clog2(NDIG);
    localparam int CW   = $clog2(WORD_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_bin, n_bin;
    logic [BW-1:0]        r_bcd, n_bcd;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_neg, n_neg;
    logic                 r_upper, n_upper;
    logic                 r_valid, n_valid;
    logic [6:0]           r_char, n_char;
    logic                 r_last, n_last;

    logic [WORD_BITS-1:0] w_raw;
    logic [WORD_BITS-1:0] w_mag;
    logic                 w_neg;
    logic [BW-1:0]        w_step_bcd;
    logic [WORD_BITS-1:0] w_step_bin;
    logic [3:0]           w_dig;

    generate
        if (WORD_BITS <= 32) begin : g_narrow
            assign w_raw = i_req.value[WORD_BITS-1:0];
        end else begin : g_wide
            assign w_raw = {{(WORD_BITS-32){1'b0}}, i_req.value};
        end
    endgenerate

    assign w_neg = (i_req.req_type == REQ_SDEC) && w_raw[WORD_BITS-1];
    assign w_mag = w_neg ? (~w_raw + {{(WORD_BITS-1){1'b0}}, 1'b1}) : w_raw;
    assign w_dig = r_bcd[r_idx*4 +: 4];

    i2a_dabble #(
        .WORD_BITS (WORD_BITS),
        .NDIG      (NDIG)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (w_step_bcd),
        .o_bin (w_step_bin)
    );

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_upper = r_upper;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg   = w_neg;
                    n_upper = (i_req.req_type == REQ_HEXU);
                    n_idx   = IW'(NDIG - 1);
                    if (i_req.req_type == REQ_HEXL || i_req.req_type == REQ_HEXU) begin
                        n_bcd   = BW'(w_mag);
                        n_state = ST_SKIP;
                    end else begin
                        n_bin   = w_mag;
                        n_bcd   = '0;
                        n_cnt   = CW'(WORD_BITS);
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = w_step_bcd;
                n_bin = w_step_bin;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (w_dig == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - IW'(1);
                end else begin
                    n_state = ST_EMIT;
                    if (r_neg) begin
                        n_valid = 1'b1;
                        n_char  = CH_MINUS;
                        n_last  = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_char  = digit_char(w_dig, r_upper);
                n_last  = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_res.char_code = r_char;
    assign o_res.last_char = r_last;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted item");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last_char |=> !o_valid)
        else $error("beat followed the last character directly");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last_char |-> busy)
        else $error("non-final beat while idle");
`endif

endmodule
